// ===== hdl/crhr_pkg.sv =====
// Package: types and constants for the counter rate history ring.
`default_nettype none
package crhr_pkg;

    typedef struct packed {
        logic        opcode;
        logic [63:0] rx_total;
        logic [63:0] tx_total;
        logic [47:0] timestamp_us;
        logic [5:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] rx_value;
        logic [63:0] tx_value;
        logic        rx_unknown;
        logic        tx_unknown;
        logic [6:0]  slots_written;
    } out_item_t;

    localparam logic [2:0] ST_STORED = 3'd0;
    localparam logic [2:0] ST_SKIP   = 3'd1;
    localparam logic [2:0] ST_FILL   = 3'd2;
    localparam logic [2:0] ST_PRIME  = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;

    localparam logic [2:0] REG_READ_IVL = 3'd0;
    localparam logic [2:0] REG_HIST_IVL = 3'd1;
    localparam logic [2:0] REG_MIN_IVL  = 3'd2;
    localparam logic [2:0] REG_MAX_IVL  = 3'd3;
    localparam logic [2:0] REG_WIDTH    = 3'd4;
    localparam logic [2:0] REG_CMODE    = 3'd5;
    localparam logic [2:0] REG_RING     = 3'd6;

    localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [19:0] US_PER_S  = 20'd1000000;

    // Element mask for a width select code
    function automatic logic [63:0] width_mask(input logic [1:0] sel);
        logic [63:0] m;
        case (sel)
            2'd0:    m = 64'h0000_0000_0000_00FF;
            2'd1:    m = 64'h0000_0000_0000_FFFF;
            2'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = ALL_ONES;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/crhr_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module crhr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== hdl/counter_rate_history_ring.sv =====
// Top level: rate history ring with APB configuration and shared serial divider.
// A store runs the 128-bit restoring division, one bit per cycle, for rx then tx
// through the same divider; a read needs no division.
// A gap fill runs a serial count division, then marks each slot unknown in turn.
// After reset a clearing pass zeroes every slot of both rings; busy is high.
// The receiver cannot stall; each result shows for one cycle on done.
`default_nettype none
module counter_rate_history_ring #(
    parameter int DEPTH     = 64,
    parameter int TIME_BITS = 48
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire crhr_pkg::in_item_t   in_item,
    output logic                      done,
    output crhr_pkg::out_item_t       out_item,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);
    localparam int AW = $clog2(DEPTH);
    localparam int NW = AW + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ0, S_READ1, S_DIV, S_STORE,
        S_CNT, S_FILL, S_DONE
    } state_t;

    // result of a record operation: status and slot count, all else zero
    function automatic crhr_pkg::out_item_t rec_out(input logic [2:0] st,
                                                    input logic [6:0] n);
        crhr_pkg::out_item_t r;
        r = '0;
        r.status = st;
        r.slots_written = n;
        return r;
    endfunction

    // configuration
    logic [31:0] rd_ivl_reg, hist_ivl_reg, min_ivl_reg, max_ivl_reg;
    logic [1:0]  wsel_reg;
    logic        cmode_reg;
    logic [6:0]  ring_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ivl_reg   <= 32'd1000000;
            hist_ivl_reg <= 32'd1000000;
            min_ivl_reg  <= 32'd500000;
            max_ivl_reg  <= 32'd1100000;
            wsel_reg     <= 2'd3;
            cmode_reg    <= 1'b1;
            ring_reg     <= 7'd64;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[4:2])
                crhr_pkg::REG_READ_IVL: rd_ivl_reg   <= pwdata;
                crhr_pkg::REG_HIST_IVL: hist_ivl_reg <= pwdata;
                crhr_pkg::REG_MIN_IVL:  min_ivl_reg  <= pwdata;
                crhr_pkg::REG_MAX_IVL:  max_ivl_reg  <= pwdata;
                crhr_pkg::REG_WIDTH:    wsel_reg     <= pwdata[1:0];
                crhr_pkg::REG_CMODE:    cmode_reg    <= pwdata[0];
                crhr_pkg::REG_RING:     ring_reg     <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            crhr_pkg::REG_READ_IVL: prdata = rd_ivl_reg;
            crhr_pkg::REG_HIST_IVL: prdata = hist_ivl_reg;
            crhr_pkg::REG_MIN_IVL:  prdata = min_ivl_reg;
            crhr_pkg::REG_MAX_IVL:  prdata = max_ivl_reg;
            crhr_pkg::REG_WIDTH:    prdata = {30'd0, wsel_reg};
            crhr_pkg::REG_CMODE:    prdata = {31'd0, cmode_reg};
            crhr_pkg::REG_RING:     prdata = {25'd0, ring_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // effective ring length, clamped to 1..DEPTH
    logic [NW-1:0] ring_len;
    always_comb
    begin
        if (ring_reg == 7'd0)
            ring_len = NW'(1);
        else if (32'(ring_reg) > 32'(DEPTH))
            ring_len = NW'(DEPTH);
        else
            ring_len = NW'(ring_reg);
    end

    // state
    state_t         state_reg;
    logic [AW-1:0]  addr_reg;
    logic [NW-1:0]  wslot_reg;
    logic [63:0]    prev_rx_reg, prev_tx_reg;
    logic [TIME_BITS-1:0] last_ts_reg;
    logic           rx_st_reg, tx_st_reg;
    crhr_pkg::in_item_t  item_reg;
    crhr_pkg::out_item_t out_reg;
    logic           done_reg;
    logic [TIME_BITS-1:0] elapsed_reg;
    logic           lane_reg;      // 0 rx, 1 tx
    logic           rx_we, tx_we;
    logic [63:0]    rx_wd, tx_wd, rx_rd, tx_rd;
    logic [63:0]    rx_val_reg;
    // shared serial divider: 128-bit dividend shifted out one bit a cycle
    logic [127:0]   dvd_reg;
    logic [64:0]    rem_reg;
    logic [63:0]    quo_reg;
    logic [7:0]     cnt_reg;
    logic [63:0]    dsr_reg;
    logic [6:0]     nfill_reg;
    logic [6:0]     written_reg;

    crhr_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_rx_ram
        (.clk(clk), .we(rx_we), .addr(addr_reg), .wdata(rx_wd), .rdata(rx_rd));
    crhr_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_tx_ram
        (.clk(clk), .we(tx_we), .addr(addr_reg), .wdata(tx_wd), .rdata(tx_rd));

    logic [63:0] wmask;
    assign wmask = crhr_pkg::width_mask(wsel_reg);

    // elapsed time; no previous sample counts as zero
    logic [TIME_BITS-1:0] ts, elapsed_c, elapsed_eff;
    assign ts          = TIME_BITS'(in_item.timestamp_us);
    assign elapsed_c   = ts - last_ts_reg;
    assign elapsed_eff = (last_ts_reg == '0) ? '0 : elapsed_c;

    // divider step
    logic [64:0] rem_sh;
    logic        sub_ok;
    assign rem_sh = {rem_reg[63:0], dvd_reg[127]};
    assign sub_ok = rem_sh >= {1'b0, dsr_reg};

    // per-lane selection of the value being stored
    logic [63:0] cur_total, cur_prev, cur_delta;
    assign cur_total   = lane_reg ? item_reg.tx_total : item_reg.rx_total;
    assign cur_prev    = lane_reg ? prev_tx_reg : prev_rx_reg;
    assign cur_delta   = cur_total - cur_prev;

    // product delta * 1e6 (64x20 multiply, registered into the dividend)
    logic [83:0] prod;
    assign prod = cur_delta * crhr_pkg::US_PER_S;

    logic [NW-1:0] wslot_inc;
    assign wslot_inc = (wslot_reg + NW'(1) < ring_len) ? wslot_reg + NW'(1) : NW'(0);

    logic [31:0] half;
    assign half = {1'b0, hist_ivl_reg[31:1]};

    // read result from the registered RAM outputs
    logic [63:0] rx_m, tx_m;
    crhr_pkg::out_item_t read_out;
    assign rx_m = rx_rd & wmask;
    assign tx_m = tx_rd & wmask;

    always_comb
    begin
        read_out = '0;
        read_out.status = crhr_pkg::ST_READ;
        if (32'(item_reg.read_index) < 32'(DEPTH))
        begin
            read_out.rx_unknown = rx_m == wmask;
            read_out.tx_unknown = tx_m == wmask;
            read_out.rx_value   = (rx_m == wmask) ? crhr_pkg::ALL_ONES : rx_m;
            read_out.tx_value   = (tx_m == wmask) ? crhr_pkg::ALL_ONES : tx_m;
        end
    end

    // RAM write control: clear, gap fill and store writes
    logic        st_rx_en, st_tx_en;
    logic [63:0] st_rx_v, st_tx_v;

    always_comb
    begin
        rx_we = 1'b0; tx_we = 1'b0;
        rx_wd = 64'd0; tx_wd = 64'd0;
        if (state_reg == S_CLEAR)
        begin
            rx_we = 1'b1; tx_we = 1'b1;
        end
        else if (state_reg == S_FILL && nfill_reg != 7'd0)
        begin
            rx_we = rx_st_reg; tx_we = tx_st_reg;
            rx_wd = wmask; tx_wd = wmask;
        end
        else if (state_reg == S_STORE)
        begin
            rx_we = st_rx_en; tx_we = st_tx_en;
            rx_wd = st_rx_v & wmask; tx_wd = st_tx_v & wmask;
        end
    end

    logic rx_unk_in, tx_unk_in;
    assign rx_unk_in = item_reg.rx_total == crhr_pkg::ALL_ONES;
    assign tx_unk_in = item_reg.tx_total == crhr_pkg::ALL_ONES;
    assign st_rx_en  = rx_st_reg || !rx_unk_in;
    assign st_tx_en  = tx_st_reg || !tx_unk_in;
    assign st_rx_v   = rx_unk_in ? crhr_pkg::ALL_ONES : rx_val_reg;
    assign st_tx_v   = tx_unk_in ? crhr_pkg::ALL_ONES : quo_reg;

    // divisor-zero or zero-delta pass-through select for the current lane
    logic        bypass;
    assign bypass = (cur_delta == 64'd0) || (elapsed_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            addr_reg    <= '0;
            wslot_reg   <= '0;
            prev_rx_reg <= '0;
            prev_tx_reg <= '0;
            last_ts_reg <= '0;
            rx_st_reg   <= 1'b0;
            tx_st_reg   <= 1'b0;
            done_reg    <= 1'b0;
            lane_reg    <= 1'b0;
            cnt_reg     <= '0;
            nfill_reg   <= '0;
            written_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    addr_reg <= addr_reg + AW'(1);
                    if (32'(addr_reg) == 32'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        item_reg    <= in_item;
                        elapsed_reg <= elapsed_eff;
                        lane_reg    <= 1'b0;
                        if (in_item.opcode)
                        begin
                            addr_reg  <= AW'(in_item.read_index);
                            state_reg <= S_READ0;
                        end
                        else if (last_ts_reg == '0 && cmode_reg)
                        begin
                            prev_rx_reg <= in_item.rx_total;
                            prev_tx_reg <= in_item.tx_total;
                            last_ts_reg <= ts;
                            out_reg     <= rec_out(crhr_pkg::ST_PRIME, 7'd0);
                            state_reg   <= S_DONE;
                        end
                        else if (rd_ivl_reg > hist_ivl_reg ||
                                 (rd_ivl_reg < hist_ivl_reg &&
                                  64'(elapsed_eff) > 64'(max_ivl_reg)))
                        begin
                            // gap: count = (elapsed - half)/hist + 1 over the divider
                            dvd_reg   <= {64'(elapsed_eff - TIME_BITS'(half)), 64'd0};
                            dsr_reg   <= 64'(hist_ivl_reg);
                            rem_reg   <= '0;
                            quo_reg   <= '0;
                            cnt_reg   <= 8'd64;
                            state_reg <= S_CNT;
                        end
                        else if (rd_ivl_reg < hist_ivl_reg &&
                                 64'(elapsed_eff) < 64'(min_ivl_reg))
                        begin
                            out_reg   <= rec_out(crhr_pkg::ST_SKIP, 7'd0);
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            cnt_reg   <= 8'd0;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_READ0:
                    state_reg <= S_READ1;
                S_READ1:
                begin
                    out_reg   <= read_out;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_DIV:
                begin
                    // cnt 0: load; 1..128: shift/subtract; 129: capture lane result
                    if (cnt_reg == 8'd0)
                    begin
                        dvd_reg <= {44'd0, prod};
                        dsr_reg <= 64'(elapsed_reg);
                        rem_reg <= '0;
                        quo_reg <= '0;
                        cnt_reg <= 8'd1;
                    end
                    else if (cnt_reg <= 8'd128)
                    begin
                        dvd_reg <= {dvd_reg[126:0], 1'b0};
                        rem_reg <= sub_ok ? rem_sh - {1'b0, dsr_reg} : rem_sh;
                        quo_reg <= {quo_reg[62:0], sub_ok};
                        cnt_reg <= cnt_reg + 8'd1;
                    end
                    else
                    begin
                        if (bypass)
                            quo_reg <= cur_delta;
                        if (!lane_reg)
                        begin
                            rx_val_reg <= bypass ? cur_delta : quo_reg;
                            lane_reg   <= 1'b1;
                            cnt_reg    <= 8'd0;
                        end
                        else
                        begin
                            addr_reg  <= wslot_reg[AW-1:0];
                            state_reg <= S_STORE;
                        end
                    end
                end
                S_STORE:
                begin
                    if (st_rx_en)
                    begin
                        rx_st_reg <= 1'b1;
                        if (!rx_unk_in) prev_rx_reg <= item_reg.rx_total;
                    end
                    if (st_tx_en)
                    begin
                        tx_st_reg <= 1'b1;
                        if (!tx_unk_in) prev_tx_reg <= item_reg.tx_total;
                    end
                    wslot_reg   <= wslot_inc;
                    last_ts_reg <= TIME_BITS'(item_reg.timestamp_us);
                    out_reg     <= rec_out(crhr_pkg::ST_STORED, 7'd1);
                    state_reg   <= S_DONE;
                end
                S_CNT:
                begin
                    if (cnt_reg != 8'd0)
                    begin
                        dvd_reg <= {dvd_reg[126:0], 1'b0};
                        rem_reg <= sub_ok ? rem_sh - {1'b0, dsr_reg} : rem_sh;
                        quo_reg <= {quo_reg[62:0], sub_ok};
                        cnt_reg <= cnt_reg - 8'd1;
                    end
                    else
                    begin
                        if (64'(elapsed_reg) < 64'(half))
                            nfill_reg <= 7'd0;
                        else if (hist_ivl_reg == 32'd0 || quo_reg >= 64'(ring_len))
                            nfill_reg <= 7'(ring_len);
                        else
                            nfill_reg <= 7'(quo_reg + 64'd1 > 64'(ring_len) ?
                                            64'(ring_len) : quo_reg + 64'd1);
                        written_reg <= '0;
                        addr_reg    <= wslot_reg[AW-1:0];
                        state_reg   <= S_FILL;
                    end
                end
                S_FILL:
                begin
                    if (nfill_reg != 7'd0)
                    begin
                        nfill_reg   <= nfill_reg - 7'd1;
                        written_reg <= written_reg + 7'd1;
                        wslot_reg   <= wslot_inc;
                        addr_reg    <= wslot_inc[AW-1:0];
                    end
                    else
                    begin
                        prev_rx_reg <= item_reg.rx_total;
                        prev_tx_reg <= item_reg.tx_total;
                        last_ts_reg <= TIME_BITS'(item_reg.timestamp_us);
                        out_reg     <= rec_out(crhr_pkg::ST_FILL, written_reg);
                        state_reg   <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy     = state_reg != S_IDLE;
    assign done     = done_reg;
    assign out_item = out_reg;
endmodule
`default_nettype wire

// ===== hdl/crhr_checker.sv =====
// Port-level checker for the rate history ring, bound to the top level.
`default_nettype none
module crhr_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done,
    input wire crhr_pkg::out_item_t out_item
);
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held two cycles");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("no busy after accept");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_item.status == crhr_pkg::ST_READ) |-> out_item.slots_written == 7'd0)
        else $error("read reported slots");
    a_rec_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_item.status != crhr_pkg::ST_READ) |->
            (!out_item.rx_unknown && !out_item.tx_unknown))
        else $error("flags on record");
endmodule

bind counter_rate_history_ring crhr_checker u_crhr_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .out_item(out_item)
);
`default_nettype wire

// ===== tb/tb_counter_rate_history_ring.sv =====
// Testbench for the counter rate history ring: directed and random items, APB setup, scoreboard.
`default_nettype none
module tb_counter_rate_history_ring;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH  = 64;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_WAIT  = 400;
    localparam int RANDOM_ITEMS = 1830;
    localparam int PHASES       = 12;

    // Rate history predictor and store of expected results
    class rate_scoreboard;
        logic [31:0] read_ivl, hist_ivl, min_ivl, max_ivl;
        logic [1:0]  width_sel;
        logic        cmode;
        logic [6:0]  ring;
        logic [63:0] hist [2][RING_DEPTH];
        logic [63:0] prev [2];
        logic        started [2];
        logic [5:0]  wslot;
        logic [47:0] last_ts;
        crhr_pkg::out_item_t pending_results[$];
        int          mismatches;
        int          results_seen;
        int          reads, stores, skips, fills, primes;

        function void clear();
            for (int h = 0; h < 2; h++)
            begin
                for (int i = 0; i < RING_DEPTH; i++)
                    hist[h][i] = '0;
                prev[h] = '0;
                started[h] = 1'b0;
            end
            wslot = '0;
            last_ts = '0;
            read_ivl = 32'd1000000;
            hist_ivl = 32'd1000000;
            min_ivl = 32'd500000;
            max_ivl = 32'd1100000;
            width_sel = 2'd3;
            cmode = 1'b1;
            ring = 7'd64;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                crhr_pkg::REG_READ_IVL: read_ivl = v;
                crhr_pkg::REG_HIST_IVL: hist_ivl = v;
                crhr_pkg::REG_MIN_IVL:  min_ivl = v;
                crhr_pkg::REG_MAX_IVL:  max_ivl = v;
                crhr_pkg::REG_WIDTH:    width_sel = v[1:0];
                crhr_pkg::REG_CMODE:    cmode = v[0];
                crhr_pkg::REG_RING:     ring = v[6:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] elem_mask();
            case (width_sel)
                2'd0:    return 64'hFF;
                2'd1:    return 64'hFFFF;
                2'd2:    return 64'hFFFF_FFFF;
                default: return crhr_pkg::ALL_ONES;
            endcase
        endfunction

        function int ring_len();
            if (ring < 1) return 1;
            if (ring > RING_DEPTH) return RING_DEPTH;
            return ring;
        endfunction

        // One history write; elapsed of zero keeps the raw delta
        function void put_rate(int h, logic [63:0] total, logic [63:0] elapsed);
            logic [63:0]  delta;
            logic [63:0]  val;
            logic [127:0] prod;
            if (!started[h])
            begin
                if (total == crhr_pkg::ALL_ONES) return;
                started[h] = 1'b1;
            end
            if (total == crhr_pkg::ALL_ONES)
                val = crhr_pkg::ALL_ONES;
            else
            begin
                delta = total - prev[h];
                if (delta != 0 && elapsed != 0)
                begin
                    prod = {64'd0, delta} * 128'd1000000;
                    prod = prod / {64'd0, elapsed};
                    val = prod[63:0];
                end
                else
                    val = delta;
                prev[h] = total;
            end
            hist[h][wslot] = val & elem_mask();
        endfunction

        function void advance();
            if (int'(wslot) + 1 < ring_len()) wslot++;
            else wslot = '0;
        endfunction

        // Work out the result of one accepted item
        function void note_item(crhr_pkg::in_item_t it);
            crhr_pkg::out_item_t r;
            logic [47:0] diff;
            logic [63:0] elapsed, m, rv, tv, half, n;
            logic        fill;
            r = '0;
            elapsed = '0;
            fill = 1'b0;
            if (it.opcode)
            begin
                m = elem_mask();
                rv = hist[0][it.read_index] & m;
                tv = hist[1][it.read_index] & m;
                r.rx_unknown = (rv == m);
                r.tx_unknown = (tv == m);
                r.rx_value = r.rx_unknown ? crhr_pkg::ALL_ONES : rv;
                r.tx_value = r.tx_unknown ? crhr_pkg::ALL_ONES : tv;
                r.status = crhr_pkg::ST_READ;
                reads++;
                pending_results.push_back(r);
                return;
            end
            if (last_ts != 0)
            begin
                diff = it.timestamp_us - last_ts;
                elapsed = {16'd0, diff};
            end
            else if (cmode)
            begin
                prev[0] = it.rx_total;
                prev[1] = it.tx_total;
                last_ts = it.timestamp_us;
                r.status = crhr_pkg::ST_PRIME;
                primes++;
                pending_results.push_back(r);
                return;
            end
            if (read_ivl > hist_ivl) fill = 1'b1;
            else if (read_ivl == hist_ivl) fill = 1'b0;
            else if (elapsed > {32'd0, max_ivl}) fill = 1'b1;
            else if (elapsed < {32'd0, min_ivl})
            begin
                r.status = crhr_pkg::ST_SKIP;
                skips++;
                pending_results.push_back(r);
                return;
            end
            if (!fill)
            begin
                put_rate(0, it.rx_total, elapsed);
                put_rate(1, it.tx_total, elapsed);
                advance();
                r.status = crhr_pkg::ST_STORED;
                r.slots_written = 7'd1;
                stores++;
            end
            else
            begin
                half = {33'd0, hist_ivl[31:1]};
                n = 0;
                if (elapsed >= half)
                begin
                    if (hist_ivl == 0) n = ring_len();
                    else n = (elapsed - half) / {32'd0, hist_ivl} + 1;
                end
                if (n > ring_len()) n = ring_len();
                for (int k = 0; k < n; k++)
                begin
                    put_rate(0, crhr_pkg::ALL_ONES, 0);
                    put_rate(1, crhr_pkg::ALL_ONES, 0);
                    advance();
                end
                prev[0] = it.rx_total;
                prev[1] = it.tx_total;
                r.status = crhr_pkg::ST_FILL;
                r.slots_written = n[6:0];
                fills++;
            end
            last_ts = it.timestamp_us;
            pending_results.push_back(r);
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(crhr_pkg::out_item_t got);
            crhr_pkg::out_item_t want;
            string     fld;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %p", got);
                return;
            end
            want = pending_results.pop_front();
            fld = "";
            if (got.status !== want.status) fld = "status";
            else if (got.rx_value !== want.rx_value) fld = "rx_value";
            else if (got.tx_value !== want.tx_value) fld = "tx_value";
            else if (got.rx_unknown !== want.rx_unknown) fld = "rx_unknown";
            else if (got.tx_unknown !== want.tx_unknown) fld = "tx_unknown";
            else if (got.slots_written !== want.slots_written) fld = "slots_written";
            if (fld != "")
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: %s differs, expected %p got %p", fld, want, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    crhr_pkg::in_item_t  in_item;
    logic        done;
    crhr_pkg::out_item_t out_item;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rate_scoreboard sb;
    int          cycles;
    logic [63:0] rx_run, tx_run;
    logic [47:0] ts_run;

    counter_rate_history_ring uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .done(done), .out_item(out_item), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Result monitor and run limit
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && done)
            sb.check_result(out_item);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // APB register write: setup then access
    task automatic reg_write(logic [2:0] idx, logic [31:0] v);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = v;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, v);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Hand one item to the block after a random gap
    task automatic send_item(crhr_pkg::in_item_t it);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_item = it;
        start = 1'b1;
        do @(posedge clk); while (busy);
        sb.note_item(it);
    endtask

    task automatic drop_start();
        @(negedge clk);
        start = 1'b0;
    endtask

    // Let every expected result arrive, then let the block settle
    task automatic drain();
        drop_start();
        while (sb.pending_results.size() != 0) @(posedge clk);
        while (busy) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic crhr_pkg::in_item_t record(logic [63:0] rx, logic [63:0] tx,
                                                  logic [47:0] ts);
        crhr_pkg::in_item_t it;
        it = '0;
        it.rx_total = rx;
        it.tx_total = tx;
        it.timestamp_us = ts;
        return it;
    endfunction

    function automatic crhr_pkg::in_item_t read_of(logic [5:0] idx);
        crhr_pkg::in_item_t it;
        it = '0;
        it.opcode = 1'b1;
        it.read_index = idx;
        it.rx_total = {$urandom, $urandom};
        it.tx_total = {$urandom, $urandom};
        it.timestamp_us = {$urandom, $urandom};
        return it;
    endfunction

    function automatic logic [63:0] next_total(logic [63:0] cur);
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return crhr_pkg::ALL_ONES;
        if (k == 1) return {$urandom, $urandom};
        if (k == 2) return cur;
        return cur + $urandom_range(0, 2000000);
    endfunction

    // Time step aimed at the skip, store and fill windows
    function automatic logic [47:0] next_step();
        logic [31:0] lo, hi;
        int k;
        lo = sb.min_ivl;
        hi = sb.max_ivl;
        k = $urandom_range(0, 11);
        case (k)
            0: return 48'd0;
            1: return (lo == 0) ? 48'd0 : {16'd0, 32'($urandom_range(0, lo - 1))};
            2, 3, 4, 5:
                return (hi >= lo) ? {16'd0, 32'($urandom_range(lo, hi))} : {16'd0, lo};
            6, 7: return {16'd0, hi} + 48'($urandom_range(1, 8000));
            8: return {$urandom, $urandom};
            default: return {16'd0, sb.hist_ivl} + 48'($urandom_range(0, 50));
        endcase
    endfunction

    // Register set for one random phase
    task automatic setup_phase(int p);
        logic [31:0] h, rd, mn, mx;
        logic [1:0]  w;
        logic [6:0]  rs;
        logic        cm;
        int          rel;
        h = $urandom_range(2, 3000);
        rel = $urandom_range(0, 3);
        rd = (rel == 0) ? h : (rel == 1) ? $urandom_range(h + 1, h + 5000)
                                         : $urandom_range(1, h - 1);
        mn = $urandom_range(0, h);
        mx = h + $urandom_range(0, h);
        w = 2'($urandom_range(0, 3));
        rs = 7'($urandom_range(2, 64));
        cm = 1'($urandom_range(0, 1));
        if (p == 0)
        begin
            // extremes: equal maximal read, history and minimum intervals, zero maximum, a two-slot ring, 8-bit width
            rd = 32'hFFFF_FFFF; h = 32'hFFFF_FFFF; mn = 32'hFFFF_FFFF; mx = 32'd0;
            w = 2'd0; rs = 7'd2; cm = 1'b0;
        end
        else if (p == 1)
        begin
            rd = 32'd1; h = 32'hFFFF_FFFF; mn = 32'd0; mx = 32'hFFFF_FFFF;
            w = 2'd3; rs = 7'd64; cm = 1'b1;
        end
        else if (p == 2)
        begin
            rd = 32'hFFFF_FFFF; h = 32'd1; mn = 32'd0; mx = 32'd0;
            w = 2'd1; rs = 7'd64;
        end
        reg_write(crhr_pkg::REG_READ_IVL, rd);
        reg_write(crhr_pkg::REG_HIST_IVL, h);
        reg_write(crhr_pkg::REG_MIN_IVL, mn);
        reg_write(crhr_pkg::REG_MAX_IVL, mx);
        reg_write(crhr_pkg::REG_WIDTH, {30'd0, w});
        reg_write(crhr_pkg::REG_CMODE, {31'd0, cm});
        reg_write(crhr_pkg::REG_RING, {25'd0, rs});
    endtask

    initial
    begin
        int per_phase;
        sb = new();
        sb.clear();
        cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        in_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: prime, stores, unknown totals, reads, extremes
        send_item(read_of(6'd0));
        send_item(record(64'd100, 64'd200, 48'd1000));
        send_item(record(64'd1100, 64'd200, 48'd1001000));
        send_item(record(64'd5000, 64'd9000, 48'd1001100));
        send_item(record(crhr_pkg::ALL_ONES, 64'd12000, 48'd2001100));
        send_item(record(64'd0, crhr_pkg::ALL_ONES, 48'd3001100));
        send_item(record(64'd7, 64'd9, 48'd8001100));
        send_item(record(64'd50, 64'd60, 48'd9001100));
        send_item(record(crhr_pkg::ALL_ONES - 1, 64'hFFFF_FFFF_0000_0000, 48'd10001100));
        send_item(record(64'd0, 64'd0, 48'hFFFF_FFFF_FFFF));
        send_item(record(64'd1000, 64'd1, 48'd999999));
        send_item(read_of(6'd0));
        send_item(read_of(6'd1));
        send_item(read_of(6'd2));
        send_item(read_of(6'd3));
        send_item(read_of(6'd63));
        drain();
        // Non-counter mode: a zero timestamp clears the last sample, so the next
        // update sees no elapsed time and keeps the raw delta
        reg_write(crhr_pkg::REG_CMODE, 32'd0);
        send_item(record(64'd10, 64'd20, 48'd0));
        send_item(record(64'd15, 64'd45, 48'd0));
        send_item(record(64'd115, 64'd45, 48'd1000000));
        send_item(read_of(sb.wslot - 6'd1));
        send_item(read_of(sb.wslot - 6'd2));
        drain();

        // Random phases, each with its own register set
        per_phase = RANDOM_ITEMS / PHASES;
        rx_run = 0;
        tx_run = 0;
        ts_run = 48'd1;
        for (int p = 0; p < PHASES; p++)
        begin
            setup_phase(p);
            for (int i = 0; i < per_phase; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(read_of(6'($urandom_range(0, 63))));
                else
                begin
                    rx_run = next_total(rx_run);
                    tx_run = next_total(tx_run);
                    ts_run = ts_run + next_step();
                    if (i < 2 && p == 0) ts_run = 48'd0;
                    else if ($urandom_range(0, 99) == 0) ts_run = 48'd0;
                    send_item(record(rx_run, tx_run, ts_run));
                    if (rx_run == crhr_pkg::ALL_ONES) rx_run = $urandom;
                    if (tx_run == crhr_pkg::ALL_ONES) tx_run = $urandom;
                end
            end
            drain();
        end

        $display("covered %0d results: %0d reads, %0d stores, %0d skips, %0d fills, %0d primes",
                 sb.results_seen, sb.reads, sb.stores, sb.skips, sb.fills, sb.primes);
        $display("%0d register phases, %0d mismatches", PHASES + 2, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
